[rtl/cotangent_laplace_entries_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cotangent Laplacian entry block
// Shared concurrent checks, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef COTANGENT_LAPLACE_ENTRIES_TOP_MACROS_SVH
`define COTANGENT_LAPLACE_ENTRIES_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Cotangent Laplacian entries: shared package
// Field widths, internal arithmetic widths, entry codes and small helpers.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int IDX_W    = 16;
	localparam int COORD_W  = 32;
	localparam int IN_W     = 3 * IDX_W + 9 * COORD_W;
	localparam int VAL_W    = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int DOT_W    = PROD_W + 2;
	localparam int MAG_W    = DOT_W;
	localparam int HALF_W   = MAG_W / 2;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int Q_W      = 32;
	localparam int U_W      = SQ_W + Q_W;
	localparam int C_W      = SQ_W + 2 * Q_W + 1;
	localparam int ROOT_STEPS = Q_W;
	localparam int LANE_DEPTH = ROOT_STEPS + 1;
	localparam int LANES    = 3;

	localparam int MAX_VERTICES = 65536;

	localparam logic signed [VAL_W-1:0] SAT_HI = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] SAT_LO = {1'b1, {(VAL_W-1){1'b0}}};

	// Order of the three entries that each corner emits.
	localparam logic [1:0] ENT_DIAG = 2'd0;
	localparam logic [1:0] ENT_NEXT = 2'd1;
	localparam logic [1:0] ENT_PREV = 2'd2;

	localparam logic [1:0] CORNER_FIRST = 2'd0;
	localparam logic [1:0] CORNER_LAST  = 2'd2;

	typedef struct packed {
		logic [2:0][IDX_W-1:0] idx;
		logic                  degen;
	} hdr_t;

	typedef struct packed {
		logic dneg;
		logic dzero;
	} dot_flag_t;

	function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = v;
		if (32'(v) >= MAX_VERTICES)
			r = IDX_W'(MAX_VERTICES - 1);
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat33(input logic signed [VAL_W:0] v);
		logic signed [VAL_W-1:0] r;
		r = v[VAL_W-1:0];
		if (v[VAL_W] != v[VAL_W-1])
			r = v[VAL_W] ? SAT_LO : SAT_HI;
		return r;
	endfunction

	function automatic logic [1:0] next_corner(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] prev_corner(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			2'd0:    r = 2'd2;
			2'd1:    r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

[rtl/cle_front.sv]
// ----------------------------------------------------------------------------
// Cotangent Laplacian entries: geometry front end
// Seven stage pipeline: edge differences, products, cross and dot sums,
// magnitudes, squares by partial products, squared cross length and scaled numerators.
// ----------------------------------------------------------------------------
module cle_front import cle_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int NUM_W = SQ_W + 2 * FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  logic [IN_W-1:0]          in_data,
	output logic                     out_vld,
	output hdr_t                     out_hdr,
	output logic [SQ_W-1:0]          out_s,
	output logic [2:0][NUM_W-1:0]    out_num,
	output dot_flag_t [2:0]          out_flag
);

	logic signed [COORD_W-1:0] pt [3][3];
	hdr_t hdr_in;

	logic [6:0] vld_s;
	// hdr_s[n] belongs to stage n+1.
	hdr_t hdr_s [7];
	logic signed [DIFF_W-1:0] d01_s1 [3];
	logic signed [DIFF_W-1:0] d02_s1 [3];
	logic signed [DIFF_W-1:0] d12_s1 [3];
	logic signed [PROD_W-1:0] cp_s2 [6];
	logic signed [PROD_W-1:0] dp_s2 [3][3];
	logic signed [CROSS_W-1:0] cr_s3 [3];
	logic signed [DOT_W-1:0] dot_s3 [3];
	logic [MAG_W-1:0] mag_s4 [6];
	dot_flag_t [2:0] flag_s4, flag_s5, flag_s6, flag_s7;
	logic [2*HALF_W-1:0] ll_s5 [6];
	logic [2*HALF_W-1:0] lh_s5 [6];
	logic [2*HALF_W-1:0] hh_s5 [6];
	logic [SQ_W-1:0] sq_s6 [6];
	logic [SQ_W-1:0] s_s7;
	logic [2:0][NUM_W-1:0] num_s7;

	for (genvar i = 0; i < 3; i++) begin : g_pt
		for (genvar k = 0; k < 3; k++) begin : g_axis
			assign pt[i][k] = in_data[3*IDX_W + COORD_W*(3*i+k) +: COORD_W];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			hdr_in.idx[i] = clamp_idx(in_data[IDX_W*i +: IDX_W]);
		hdr_in.degen = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[5:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: edge vectors.
			hdr_s[0] <= hdr_in;
			for (int k = 0; k < 3; k++) begin
				d01_s1[k] <= DIFF_W'(pt[1][k]) - DIFF_W'(pt[0][k]);
				d02_s1[k] <= DIFF_W'(pt[2][k]) - DIFF_W'(pt[0][k]);
				d12_s1[k] <= DIFF_W'(pt[2][k]) - DIFF_W'(pt[1][k]);
			end

			// Stage 2: products for the cross product and the three corner dots.
			hdr_s[1] <= hdr_s[0];
			cp_s2[0] <= d01_s1[1] * d02_s1[2];
			cp_s2[1] <= d01_s1[2] * d02_s1[1];
			cp_s2[2] <= d01_s1[2] * d02_s1[0];
			cp_s2[3] <= d01_s1[0] * d02_s1[2];
			cp_s2[4] <= d01_s1[0] * d02_s1[1];
			cp_s2[5] <= d01_s1[1] * d02_s1[0];
			for (int k = 0; k < 3; k++) begin
				dp_s2[0][k] <= d01_s1[k] * d02_s1[k];
				dp_s2[1][k] <= d01_s1[k] * d12_s1[k];
				dp_s2[2][k] <= d02_s1[k] * d12_s1[k];
			end

			// Stage 3: cross components and dots. The middle corner uses the
			// reversed first edge, so its sum changes sign.
			hdr_s[2] <= hdr_s[1];
			for (int k = 0; k < 3; k++)
				cr_s3[k] <= CROSS_W'(cp_s2[2*k]) - CROSS_W'(cp_s2[2*k+1]);
			dot_s3[0] <= DOT_W'(dp_s2[0][0]) + DOT_W'(dp_s2[0][1]) + DOT_W'(dp_s2[0][2]);
			dot_s3[1] <= -(DOT_W'(dp_s2[1][0]) + DOT_W'(dp_s2[1][1]) + DOT_W'(dp_s2[1][2]));
			dot_s3[2] <= DOT_W'(dp_s2[2][0]) + DOT_W'(dp_s2[2][1]) + DOT_W'(dp_s2[2][2]);

			// Stage 4: magnitudes and sign flags; zero area is known here.
			hdr_s[3] <= '{idx: hdr_s[2].idx,
				degen: (cr_s3[0] == '0) && (cr_s3[1] == '0) && (cr_s3[2] == '0)};
			for (int k = 0; k < 3; k++) begin
				mag_s4[k] <= cr_s3[k][CROSS_W-1] ? MAG_W'(-cr_s3[k]) : MAG_W'(cr_s3[k]);
				mag_s4[3+k] <= dot_s3[k][DOT_W-1] ? MAG_W'(-dot_s3[k]) : MAG_W'(dot_s3[k]);
				flag_s4[k] <= '{dneg: dot_s3[k][DOT_W-1], dzero: (dot_s3[k] == '0)};
			end

			// Stage 5: partial products of each square from two halves.
			hdr_s[4] <= hdr_s[3];
			flag_s5 <= flag_s4;
			for (int j = 0; j < 6; j++) begin
				ll_s5[j] <= mag_s4[j][HALF_W-1:0] * mag_s4[j][HALF_W-1:0];
				lh_s5[j] <= mag_s4[j][HALF_W-1:0] * mag_s4[j][MAG_W-1:HALF_W];
				hh_s5[j] <= mag_s4[j][MAG_W-1:HALF_W] * mag_s4[j][MAG_W-1:HALF_W];
			end

			// Stage 6: squares; the cross term appears twice, hence one extra shift.
			hdr_s[5] <= hdr_s[4];
			flag_s6 <= flag_s5;
			for (int j = 0; j < 6; j++)
				sq_s6[j] <= (SQ_W'(hh_s5[j]) << (2 * HALF_W))
					+ (SQ_W'(lh_s5[j]) << (HALF_W + 1)) + SQ_W'(ll_s5[j]);

			// Stage 7: squared cross length and scaled squared dots.
			hdr_s[6] <= hdr_s[5];
			flag_s7 <= flag_s6;
			s_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			for (int k = 0; k < 3; k++)
				num_s7[k] <= NUM_W'(sq_s6[3+k]) << (2 * FRAC_BITS);
		end
	end

	assign out_vld  = vld_s[6];
	assign out_hdr  = hdr_s[6];
	assign out_s    = s_s7;
	assign out_num  = num_s7;
	assign out_flag = flag_s7;

endmodule

[rtl/cle_lane.sv]
// ----------------------------------------------------------------------------
// Cotangent Laplacian entries: cotangent lane
// Pipelined square-root quotient, one result bit per stage: finds the largest
// q with q*q*S <= num, keeping q*q*S and q*S so each stage only shifts and adds.
// ----------------------------------------------------------------------------
module cle_lane import cle_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int NUM_W = SQ_W + 2 * FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [SQ_W-1:0]          s_in,
	input  logic [NUM_W-1:0]         num_in,
	input  dot_flag_t                flag_in,
	input  logic                     degen_in,
	output logic signed [VAL_W-1:0]  cot
);

	localparam logic [Q_W-1:0] Q_HALF = {1'b1, {(Q_W-1){1'b0}}};

	logic [NUM_W-1:0] t_s   [ROOT_STEPS];
	logic [U_W-1:0]   u_s   [ROOT_STEPS];
	logic [Q_W-1:0]   q_s   [ROOT_STEPS];
	logic [SQ_W-1:0]  s_s   [ROOT_STEPS];
	logic [NUM_W-1:0] num_s [ROOT_STEPS];
	dot_flag_t        fl_s  [ROOT_STEPS];
	logic             dg_s  [ROOT_STEPS];

	logic signed [VAL_W-1:0] cot_s33;
	logic [Q_W-1:0] q_fin;
	dot_flag_t fl_fin;

	for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
		localparam int B = ROOT_STEPS - 1 - g;
		logic [NUM_W-1:0] t_in;
		logic [U_W-1:0]   u_in;
		logic [Q_W-1:0]   q_in;
		logic [SQ_W-1:0]  s_g;
		logic [NUM_W-1:0] num_g;
		dot_flag_t        fl_g;
		logic             dg_g;
		logic [C_W-1:0]   cand;
		logic             take;

		if (g == 0) begin : g_first
			assign t_in  = '0;
			assign u_in  = '0;
			assign q_in  = '0;
			assign s_g   = s_in;
			assign num_g = num_in;
			assign fl_g  = flag_in;
			assign dg_g  = degen_in;
		end else begin : g_rest
			assign t_in  = t_s[g-1];
			assign u_in  = u_s[g-1];
			assign q_in  = q_s[g-1];
			assign s_g   = s_s[g-1];
			assign num_g = num_s[g-1];
			assign fl_g  = fl_s[g-1];
			assign dg_g  = dg_s[g-1];
		end

		// (q + 2^B)^2 * S = q^2*S + 2^(B+1)*q*S + 2^(2B)*S
		assign cand = C_W'(t_in) + (C_W'(u_in) << (B + 1)) + (C_W'(s_g) << (2 * B));
		assign take = (cand <= C_W'(num_g));

		always_ff @(posedge clk) begin
			if (adv) begin
				t_s[g]   <= take ? NUM_W'(cand) : t_in;
				u_s[g]   <= take ? (u_in + (U_W'(s_g) << B)) : u_in;
				q_s[g]   <= take ? (q_in | (Q_W'(1) << B)) : q_in;
				s_s[g]   <= s_g;
				num_s[g] <= num_g;
				fl_s[g]  <= fl_g;
				dg_s[g]  <= dg_g;
			end
		end
	end

	assign q_fin  = q_s[ROOT_STEPS-1];
	assign fl_fin = fl_s[ROOT_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fl_fin.dzero)
				cot_s33 <= '0;
			else if (dg_s[ROOT_STEPS-1])
				cot_s33 <= fl_fin.dneg ? SAT_LO : SAT_HI;
			else if (fl_fin.dneg)
				cot_s33 <= (q_fin > Q_HALF) ? SAT_LO : $signed(Q_W'(0) - q_fin);
			else
				cot_s33 <= q_fin[Q_W-1] ? SAT_HI : $signed(q_fin);
		end
	end

	assign cot = cot_s33;

endmodule

[rtl/cle_merge.sv]
// ----------------------------------------------------------------------------
// Cotangent Laplacian entries: merge and output sequencer
// Combines the three lane cotangents into diagonal and off-diagonal values
// and emits the nine entries of a triangle, one per request.
// ----------------------------------------------------------------------------
`include "cotangent_laplace_entries_top_macros.svh"

module cle_merge import cle_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	output logic                     in_ready,
	input  hdr_t                     in_hdr,
	input  logic [2:0][VAL_W-1:0]    in_cot,
	output logic                     out_vld,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic [VAL_W-1:0]         out_value,
	output logic                     out_degen,
	output logic                     out_last
);

	logic       busy_q;
	logic [1:0] corner_q;
	logic [1:0] kind_q;
	logic [2:0][IDX_W-1:0] idx_q;
	logic       degen_q;
	logic [2:0][VAL_W-1:0] diag_q;
	logic [2:0][VAL_W-1:0] neg_q;

	logic       load;
	logic [1:0] jn;
	logic [1:0] jp;

	assign out_vld  = busy_q;
	assign out_last = (corner_q == CORNER_LAST) && (kind_q == ENT_PREV);
	assign in_ready = !busy_q || (out_ready && out_last);
	assign load     = in_vld && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			corner_q <= CORNER_FIRST;
			kind_q   <= ENT_DIAG;
		end else if (load) begin
			busy_q   <= 1'b1;
			corner_q <= CORNER_FIRST;
			kind_q   <= ENT_DIAG;
		end else if (busy_q && out_ready) begin
			if (out_last) begin
				busy_q <= 1'b0;
			end else begin
				case (kind_q)
					ENT_DIAG: kind_q <= ENT_NEXT;
					ENT_NEXT: kind_q <= ENT_PREV;
					default: begin
						kind_q   <= ENT_DIAG;
						corner_q <= next_corner(corner_q);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q   <= in_hdr.idx;
			degen_q <= in_hdr.degen;
			for (int i = 0; i < 3; i++) begin
				diag_q[i] <= sat33({in_cot[next_corner(2'(i))][VAL_W-1],
					in_cot[next_corner(2'(i))]}
					+ {in_cot[prev_corner(2'(i))][VAL_W-1], in_cot[prev_corner(2'(i))]});
				neg_q[i] <= sat33((VAL_W+1)'(0) - {in_cot[i][VAL_W-1], in_cot[i]});
			end
		end
	end

	assign jn = next_corner(corner_q);
	assign jp = prev_corner(corner_q);

	always_comb begin
		out_row   = idx_q[corner_q];
		out_degen = degen_q;
		case (kind_q)
			ENT_DIAG: begin
				out_col   = idx_q[corner_q];
				out_value = diag_q[corner_q];
			end
			ENT_NEXT: begin
				out_col   = idx_q[jn];
				out_value = neg_q[jp];
			end
			default: begin
				out_col   = idx_q[jp];
				out_value = neg_q[jn];
			end
		endcase
	end

	`CLE_ASSERT_NEXT(a_merge_hold, busy_q && !out_ready, busy_q && $stable(corner_q) && $stable(kind_q), "entry sequence moved while stalled")
	`CLE_ASSERT_NEXT(a_merge_nogap, out_vld && out_ready && !out_last, out_vld, "entry sequence broke off before the ninth entry")
	`CLE_ASSERT_HOLDS(a_merge_noloss, load, !busy_q || out_last, "new triangle taken over one still being emitted")

endmodule

[rtl/cotangent_laplace_entries_top.sv]
// The first entry of a triangle is shown once its request has passed the front end, the lanes and the merge registers.
// Throughput: nine entries per triangle, one entry per cycle while m_tready is high; set by the output channel.
// The 7-stage front end and the 33-stage lanes take one triangle per cycle when not stalled.
// Reset: arst_n clears all valid bits and the entry sequencer at once; no clearing pass.
// ----------------------------------------------------------------------------
// Cotangent Laplacian entries: top level
// Front end, three cotangent lanes (one per corner), and the merging sequencer.
// ----------------------------------------------------------------------------
`include "cotangent_laplace_entries_top_macros.svh"

module cotangent_laplace_entries_top import cle_pkg::*; #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// a_index, b_index, c_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// row_index, col_index, entry_value
	output logic [63:0]       m_tdata,
	// degenerate
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int NUM_W = SQ_W + 2 * COORD_FRAC_BITS;

	logic adv;
	logic merge_ready;

	logic                  front_vld;
	hdr_t                  front_hdr;
	logic [SQ_W-1:0]       front_s;
	logic [2:0][NUM_W-1:0] front_num;
	dot_flag_t [2:0]       front_flag;

	logic [2:0][VAL_W-1:0] lane_cot;

	logic [LANE_DEPTH-1:0] lane_vld_q;
	hdr_t                  hdr_q [LANE_DEPTH];

	logic [IDX_W-1:0] row;
	logic [IDX_W-1:0] col;
	logic [VAL_W-1:0] value;

	// Every pipeline register moves together; a held triangle at the lane end stops them.
	assign adv      = !lane_vld_q[LANE_DEPTH-1] || merge_ready;
	assign s_tready = adv;

	cle_front #(.FRAC_BITS(COORD_FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (s_tvalid),
		.in_data  (s_tdata),
		.out_vld  (front_vld),
		.out_hdr  (front_hdr),
		.out_s    (front_s),
		.out_num  (front_num),
		.out_flag (front_flag)
	);

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		logic signed [VAL_W-1:0] cot;

		cle_lane #(.FRAC_BITS(COORD_FRAC_BITS)) u_lane (
			.clk      (clk),
			.adv      (adv),
			.s_in     (front_s),
			.num_in   (front_num[c]),
			.flag_in  (front_flag[c]),
			.degen_in (front_hdr.degen),
			.cot      (cot)
		);

		assign lane_cot[c] = cot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_vld_q <= '0;
		end else if (adv) begin
			lane_vld_q <= {lane_vld_q[LANE_DEPTH-2:0], front_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_q[0] <= front_hdr;
			for (int i = 1; i < LANE_DEPTH; i++)
				hdr_q[i] <= hdr_q[i-1];
		end
	end

	cle_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (lane_vld_q[LANE_DEPTH-1]),
		.in_ready  (merge_ready),
		.in_hdr    (hdr_q[LANE_DEPTH-1]),
		.in_cot    (lane_cot),
		.out_vld   (m_tvalid),
		.out_ready (m_tready),
		.out_row   (row),
		.out_col   (col),
		.out_value (value),
		.out_degen (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {value, col, row};

	`CLE_ASSERT_NEXT(a_top_stall, lane_vld_q[LANE_DEPTH-1] && !s_tready, lane_vld_q[LANE_DEPTH-1], "triangle at lane end lost while stalled")
	`CLE_ASSERT_NEXT(a_top_drain, m_tvalid && m_tready && m_tlast && !lane_vld_q[LANE_DEPTH-1], !m_tvalid, "entry shown with no triangle behind it")
	`CLE_ASSERT_HOLDS(a_top_ready, !lane_vld_q[LANE_DEPTH-1], s_tready, "request refused with an empty lane end")

endmodule
